>>> hw/rtl/tis_pkg.sv
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types, widths, constants and helper functions of the inertial
// scroll core.
// ----------------------------------------------------------------------------
package tis_pkg;

  // Field and datapath widths
  localparam int DELTA_W    = 8;   // raw delta per axis
  localparam int RAW_W      = 9;   // delta after negation or coast step
  localparam int VEL_W      = 17;  // velocity, 8 fractional bits, |v| <= 32768
  localparam int VMAG_W     = 16;  // velocity magnitude
  localparam int NUM_W      = 18;  // 2*vel + raw*256
  localparam int NMAG_W     = 17;  // magnitude of the smoothing numerator
  localparam int CMAG_W     = 8;   // coast step magnitude, at most 204
  localparam int ACC_W      = 10;  // accumulator plus step, |x| <= 403
  localparam int MAG_W      = 9;   // dividend magnitude
  localparam int DIVR_W     = 8;   // speed divisor
  localparam int Q_W        = 10;  // signed quotient before saturation
  localparam int OUT_W      = 8;
  localparam int SPEED_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

  // Reciprocal constants: x/3 = (x*43691) >> 17 exact for x < 2^17,
  // x/5 = (x*52429) >> 18 exact for x < 2^18
  localparam logic [15:0] RECIP3    = 16'd43691;
  localparam int          RECIP3_SH = 17;
  localparam logic [15:0] RECIP5    = 16'd52429;
  localparam int          RECIP5_SH = 18;
  localparam logic [7:0]  DECAY     = 8'd235;
  localparam logic [VMAG_W-1:0] VEL_MIN_ABS = VMAG_W'(2048);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INERTIA = 3'd3;

  // Lane sequencer states
  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL,
    LN_UPD,
    LN_DIV,
    LN_DONE
  } lane_state_e;

  // Per-frame control handed to each lane
  typedef struct packed {
    logic enable;
    logic invert;
    logic coast_en;
    logic active;
  } lane_ctrl_t;

  // Lane status seen by the top level and the merge stage
  typedef struct packed {
    logic idle;
    logic done;
  } lane_status_t;

  // Speed table: level zero reads as 100, levels above ten saturate
  function automatic logic [DIVR_W-1:0] div_for_level(input logic [SPEED_W-1:0] lvl);
    logic [DIVR_W-1:0] d;
    case (lvl)
      4'd0:    d = 8'd100;
      4'd1:    d = 8'd200;
      4'd2:    d = 8'd150;
      4'd3:    d = 8'd100;
      4'd4:    d = 8'd75;
      4'd5:    d = 8'd55;
      4'd6:    d = 8'd40;
      4'd7:    d = 8'd28;
      4'd8:    d = 8'd20;
      4'd9:    d = 8'd14;
      default: d = 8'd10;
    endcase
    return d;
  endfunction

  // Clamp a quotient to the signed output byte
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Q_W-1:0] q);
    logic signed [OUT_W-1:0] r;
    if (q > Q_W'(127)) begin
      r = 8'sd127;
    end else if (q < -Q_W'(128)) begin
      r = -8'sd128;
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/trackpad_inertial_scroll_core.sv
// ----------------------------------------------------------------------------
// trackpad_inertial_scroll_core
// Scales one frame of horizontal and vertical scroll deltas per transfer,
// with velocity smoothing and inertial coasting after release. Each axis
// runs in its own lane and the results leave as one output transfer. An
// enabled frame passes through the multiply and update states and then a
// restoring divide of the accumulator by the speed divisor; a new frame is
// accepted only after both lanes have handed on their results. A disabled
// frame is answered with zeros and touches no state. The output register
// lets the next frame be accepted while a result waits. There is no
// clearing pass after reset; write configuration only while idle.
// ----------------------------------------------------------------------------
module trackpad_inertial_scroll_core
  import tis_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [DELTA_W-1:0] scroll_h_i,
  input  logic signed [DELTA_W-1:0] scroll_v_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [OUT_W-1:0]   out_h_o,
  output logic signed [OUT_W-1:0]   out_v_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  logic               enable_q;
  logic               invert_q;
  logic [SPEED_W-1:0] speed_q;
  logic               inertia_q;
  logic               clear_vel;
  logic               in_xfer;
  logic               take;
  lane_ctrl_t         ctrl;
  lane_status_t       st_h;
  lane_status_t       st_v;
  logic [DIVR_W-1:0]  divisor;
  logic signed [Q_W-1:0] q_h;
  logic signed [Q_W-1:0] q_v;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      invert_q  <= 1'b1;
      speed_q   <= SPEED_W'(3);
      inertia_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:  enable_q  <= cfg_data_i[0];
        CFG_INVERT:  invert_q  <= cfg_data_i[0];
        CFG_SPEED:   speed_q   <= cfg_data_i[SPEED_W-1:0];
        CFG_INERTIA: inertia_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Switching inertia off drops any velocity left over
  assign clear_vel = cfg_we_i & (cfg_idx_i == CFG_INERTIA) & ~cfg_data_i[0];

  // Accept a frame only when both lanes are free
  assign in_ready_o = st_h.idle & st_v.idle;
  assign in_xfer    = in_valid_i & in_ready_o;

  assign ctrl.enable   = enable_q;
  assign ctrl.invert   = invert_q;
  assign ctrl.coast_en = inertia_q;
  assign ctrl.active   = (scroll_h_i != '0) | (scroll_v_i != '0);
  assign divisor       = div_for_level(speed_q);

  tis_lane u_lane_h (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .ctrl_i      (ctrl),
    .delta_i     (scroll_h_i),
    .divisor_i   (divisor),
    .clear_vel_i (clear_vel),
    .take_i      (take),
    .status_o    (st_h),
    .q_o         (q_h)
  );

  tis_lane u_lane_v (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .ctrl_i      (ctrl),
    .delta_i     (scroll_v_i),
    .divisor_i   (divisor),
    .clear_vel_i (clear_vel),
    .take_i      (take),
    .status_o    (st_v),
    .q_o         (q_v)
  );

  tis_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_h_i      (st_h),
    .st_v_i      (st_v),
    .q_h_i       (q_h),
    .q_v_i       (q_v),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_h_o     (out_h_o),
    .out_v_o     (out_v_o),
    .take_o      (take)
  );

endmodule

>>> hw/rtl/tis_div.sv
// ----------------------------------------------------------------------------
// tis_div
// Restoring radix-2 divider of an unsigned accumulator magnitude by the
// speed divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tis_div
  import tis_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MAG_W-1:0]  dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic              done_o,
  output logic [MAG_W-1:0]  quot_o,
  output logic [DIVR_W-1:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     quo_q, quo_d;
  logic [DIVR_W-1:0]    rem_q, rem_d;
  logic [DIVR_W-1:0]    dvs_q, dvs_d;
  logic [DIVR_W:0]      trial;
  logic [DIVR_W:0]      diff;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(MAG_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[MAG_W-2:0], fits};
      rem_d = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/tis_lane.sv
// ----------------------------------------------------------------------------
// tis_lane
// One scroll axis: velocity smoothing or coasting, accumulation and
// scaling by the speed divisor through its own iterative divider.
// ----------------------------------------------------------------------------
module tis_lane
  import tis_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  lane_ctrl_t                ctrl_i,
  input  logic signed [DELTA_W-1:0] delta_i,
  input  logic [DIVR_W-1:0]         divisor_i,
  input  logic                      clear_vel_i,
  input  logic                      take_i,
  output lane_status_t              status_o,
  output logic signed [Q_W-1:0]     q_o
);

  lane_state_e state_q, state_d;

  lane_ctrl_t               ctrl_q;
  logic signed [RAW_W-1:0]  raw_in_q;
  logic [DIVR_W-1:0]        dvs_q;
  logic signed [VEL_W-1:0]  vel_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [VMAG_W-1:0]        q3_q;
  logic                     num_neg_q;
  logic [CMAG_W-1:0]        cmag_q;
  logic [VMAG_W-1:0]        dmag_q;
  logic                     vel_neg_q;
  logic                     sum_neg_q;
  logic signed [Q_W-1:0]    q_q;

  logic signed [RAW_W-1:0]  raw_in;
  logic signed [NUM_W-1:0]  num;
  logic signed [NUM_W-1:0]  num_abs;
  logic signed [VEL_W-1:0]  vel_abs;
  logic [VMAG_W-1:0]        vel_mag;
  logic [NMAG_W+15:0]       prod3;
  logic [VMAG_W-5+15:0]     prodc;
  logic [VMAG_W+7:0]        prodd;
  logic signed [RAW_W-1:0]  cstep;
  logic signed [RAW_W-1:0]  raw_sel;
  logic signed [VEL_W-1:0]  vel_upd;
  logic signed [VEL_W-1:0]  vel_smooth;
  logic signed [VEL_W-1:0]  vel_decay;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  sum_abs;
  logic                     div_start;
  logic                     div_done;
  logic [MAG_W-1:0]         div_quot;
  logic [DIVR_W-1:0]        div_rem;
  logic signed [Q_W-1:0]    quot_s;
  logic signed [ACC_W-1:0]  rem_s;

  // Negate the incoming delta for natural scrolling when invert is set
  assign raw_in = ctrl_i.invert ? -RAW_W'(delta_i) : RAW_W'(delta_i);

  // Smoothing numerator 2*vel + raw*256 and its magnitude
  assign num     = (NUM_W'(vel_q) <<< 1) + NUM_W'($signed({raw_in_q, 8'b0}));
  assign num_abs = num[NUM_W-1] ? -num : num;
  assign prod3   = num_abs[NMAG_W-1:0] * RECIP3;

  // Velocity magnitude for the coast step (|v|/160) and the decay (|v|*235/256)
  assign vel_abs = vel_q[VEL_W-1] ? -vel_q : vel_q;
  assign vel_mag = vel_abs[VMAG_W-1:0];
  assign prodc   = vel_mag[VMAG_W-1:5] * RECIP5;
  assign prodd   = vel_mag * DECAY;

  // Pick the step and the new velocity for this frame
  assign cstep      = vel_neg_q ? -RAW_W'(cmag_q) : RAW_W'(cmag_q);
  assign vel_smooth = num_neg_q ? -VEL_W'(q3_q) : VEL_W'(q3_q);
  assign vel_decay  = (dmag_q < VEL_MIN_ABS) ? '0 :
                      (vel_neg_q ? -VEL_W'(dmag_q) : VEL_W'(dmag_q));

  always_comb begin
    if (ctrl_q.active) begin
      raw_sel = raw_in_q;
      vel_upd = vel_smooth;
    end else if (ctrl_q.coast_en) begin
      raw_sel = cstep;
      vel_upd = vel_decay;
    end else begin
      raw_sel = '0;
      vel_upd = vel_q;
    end
  end

  // Accumulate and split into sign and magnitude for the divider
  assign sum     = acc_q + ACC_W'(raw_sel);
  assign sum_abs = sum[ACC_W-1] ? -sum : sum;

  // Restore signs: truncation toward zero gives both results the dividend sign
  assign quot_s = sum_neg_q ? -Q_W'(div_quot) : Q_W'(div_quot);
  assign rem_s  = sum_neg_q ? -ACC_W'(div_rem) : ACC_W'(div_rem);

  tis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs[MAG_W-1:0]),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LN_IDLE: begin
        if (start_i) begin
          state_d = ctrl_i.enable ? LN_MUL : LN_DONE;
        end
      end
      LN_MUL:  state_d = LN_UPD;
      LN_UPD:  state_d = LN_DIV;
      LN_DIV: begin
        if (div_done) begin
          state_d = LN_DONE;
        end
      end
      LN_DONE: begin
        if (take_i) begin
          state_d = LN_IDLE;
        end
      end
      default: state_d = LN_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    div_start     = 1'b0;
    status_o.idle = 1'b0;
    status_o.done = 1'b0;
    unique case (state_q)
      LN_IDLE: status_o.idle = 1'b1;
      LN_UPD:  div_start     = 1'b1;
      LN_DONE: status_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Persistent axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      acc_q <= '0;
    end else begin
      if (clear_vel_i) begin
        vel_q <= '0;
      end else if (state_q == LN_UPD) begin
        vel_q <= vel_upd;
      end
      if (state_q == LN_DIV && div_done) begin
        acc_q <= rem_s;
      end
    end
  end

  // Frame payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      LN_IDLE: begin
        if (start_i) begin
          ctrl_q   <= ctrl_i;
          raw_in_q <= raw_in;
          dvs_q    <= divisor_i;
          q_q      <= '0;
        end
      end
      LN_MUL: begin
        q3_q      <= prod3[RECIP3_SH +: VMAG_W];
        num_neg_q <= num[NUM_W-1];
        cmag_q    <= prodc[RECIP5_SH +: CMAG_W];
        dmag_q    <= prodd[8 +: VMAG_W];
        vel_neg_q <= vel_q[VEL_W-1];
      end
      LN_UPD: sum_neg_q <= sum[ACC_W-1];
      LN_DIV: begin
        if (div_done) begin
          q_q <= quot_s;
        end
      end
      default: ;
    endcase
  end

  assign q_o = q_q;

endmodule

>>> hw/rtl/tis_merge.sv
// ----------------------------------------------------------------------------
// tis_merge
// Joins the two lane results into one saturated output transfer and holds
// it in the output register until it is taken.
// ----------------------------------------------------------------------------
module tis_merge
  import tis_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_status_t            st_h_i,
  input  lane_status_t            st_v_i,
  input  logic signed [Q_W-1:0]   q_h_i,
  input  logic signed [Q_W-1:0]   q_v_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [OUT_W-1:0] out_h_o,
  output logic signed [OUT_W-1:0] out_v_o,
  output logic                    take_o
);

  logic                    valid_q;
  logic signed [OUT_W-1:0] out_h_q;
  logic signed [OUT_W-1:0] out_v_q;

  // Take both lanes once the output register is free or drains this cycle
  assign take_o = st_h_i.done & st_v_i.done & (~valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_h_q <= sat_out(q_h_i);
      out_v_q <= sat_out(q_v_i);
    end
  end

  assign out_valid_o = valid_q;
  assign out_h_o     = out_h_q;
  assign out_v_o     = out_v_q;

endmodule

>>> hw/rtl/tis_checker.sv
// ----------------------------------------------------------------------------
// tis_checker
// Port-level checks of the inertial scroll core, bound to the top level.
// ----------------------------------------------------------------------------
module tis_checker
  import tis_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic signed [DELTA_W-1:0] scroll_h_i,
  input logic signed [DELTA_W-1:0] scroll_v_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [OUT_W-1:0]   out_h_o,
  input logic signed [OUT_W-1:0]   out_v_o,
  input logic                      cfg_we_i,
  input logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input logic [CFG_DATA_W-1:0]     cfg_data_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_h_o) && $stable(out_v_o))
    else $error("stalled output transfer changed");

  // One frame in flight: ready drops after an input transfer
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a frame is in flight");

  // A new frame cannot produce its result in the very next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after an input transfer");

  // Scaled steps never exceed the largest reachable magnitude
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_h_o >= -8'sd40 && out_h_o <= 8'sd40 &&
                    out_v_o >= -8'sd40 && out_v_o <= 8'sd40)
    else $error("output step out of range");

endmodule

bind trackpad_inertial_scroll_core tis_checker u_tis_checker (.*);
